>>> hw/rtl/shp_pkg.sv
// ----------------------------------------------------------------------------
// shp_pkg: shared types and constants of the slot heap allocator
// Command and response payloads, result codes and sequencer states.
// ----------------------------------------------------------------------------
package shp_pkg;

	localparam int HEAP_SLOTS_DEF = 32;
	localparam int TAG_W          = 4;
	localparam int SLOT_W         = 5;

	typedef enum logic [1:0] {
		ACT_ALLOC   = 2'd0,
		ACT_MARK    = 2'd1,
		ACT_COLLECT = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		KIND_ALLOC     = 2'd0,
		KIND_FREED     = 2'd1,
		KIND_EXHAUSTED = 2'd2,
		KIND_DONE      = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SWEEP,
		ST_EMIT,
		ST_FINAL
	} state_t;

	typedef struct packed {
		action_t             action;
		logic [TAG_W-1:0]    type_tag;
		logic [SLOT_W-1:0]   slot_index;
	} cmd_t;

	typedef struct packed {
		kind_t               kind;
		logic [SLOT_W-1:0]   slot;
		logic [TAG_W-1:0]    freed_tag;
		logic                last;
	} rsp_t;

	typedef struct packed {
		logic vld;
		rsp_t item;
	} res_t;

endpackage

>>> hw/rtl/shp_ram.sv
// ----------------------------------------------------------------------------
// shp_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module shp_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> hw/rtl/shp_ctrl.sv
// ----------------------------------------------------------------------------
// shp_ctrl: slot sequencer
// Walks the slot bits one slot per cycle for the allocation scan and the
// sweep, the sweep holding at each freed slot until its notice is taken;
// keeps the in-use and mark bits and owns the tag store.
module shp_ctrl
	import shp_pkg::*;
#(
	parameter int HEAP_SLOTS = HEAP_SLOTS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_stall,
	input  cmd_t cmd,
	input  logic res_ready,
	output res_t res
);

	localparam int NW = $clog2(HEAP_SLOTS + 1);
	localparam int IW = $clog2(HEAP_SLOTS);
	localparam int MW = (NW > SLOT_W) ? NW : SLOT_W;
	localparam logic [NW-1:0] PTR_END  = NW'(HEAP_SLOTS);
	localparam logic [IW-1:0] LAST_IDX = IW'(HEAP_SLOTS - 1);
	localparam logic [MW-1:0] SLOTS_MW = MW'(HEAP_SLOTS);

	state_t                  state_q, state_d;
	logic [NW-1:0]           ptr_q;
	logic [IW-1:0]           idx_q;
	action_t                 act_q;
	logic [TAG_W-1:0]        tag_q;
	logic                    swept_q;
	kind_t                   fin_kind_q;
	logic [IW-1:0]           fin_slot_q;
	logic [HEAP_SLOTS-1:0]   in_use_q;
	logic [HEAP_SLOTS-1:0]   mark_q;

	logic                    cmd_take;
	logic [MW-1:0]           mk_ext;
	logic [IW-1:0]           mk_ix;
	logic                    mark_hit;
	logic                    ptr_end;
	logic [IW-1:0]           ptr_ix;
	logic                    ptr_busy;
	logic                    swp_live;
	logic                    swp_free;
	logic                    swp_last;
	logic                    adv;
	logic                    ram_wr_en;
	logic                    ram_rd_en;
	logic [TAG_W-1:0]        ram_rd_data;

	assign cmd_take = cmd_valid && (state_q == ST_IDLE);
	assign mk_ext   = MW'(cmd.slot_index);
	assign mk_ix    = mk_ext[IW-1:0];
	assign mark_hit = cmd_take && (cmd.action == ACT_MARK) && (mk_ext < SLOTS_MW)
		&& in_use_q[mk_ix];

	assign ptr_end  = (ptr_q == PTR_END);
	assign ptr_ix   = ptr_q[IW-1:0];
	assign ptr_busy = in_use_q[ptr_ix];

	// slots at or above the pointer only lose their mark
	assign swp_live = (NW'(idx_q) < ptr_q) && in_use_q[idx_q];
	assign swp_free = (state_q == ST_SWEEP) && swp_live && !mark_q[idx_q];
	assign swp_last = (idx_q == LAST_IDX);
	assign adv      = ((state_q == ST_SWEEP) && !swp_free)
		|| ((state_q == ST_EMIT) && res_ready);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_take) begin
					if (cmd.action == ACT_ALLOC) begin
						state_d = ST_SCAN;
					end else if (cmd.action == ACT_COLLECT) begin
						state_d = ST_SWEEP;
					end
				end
			end
			ST_SCAN: begin
				if (ptr_end) begin
					state_d = swept_q ? ST_FINAL : ST_SWEEP;
				end else if (!ptr_busy) begin
					state_d = ST_FINAL;
				end
			end
			ST_SWEEP, ST_EMIT: begin
				if (swp_free) begin
					state_d = ST_EMIT;
				end else if (adv) begin
					if (swp_last) begin
						state_d = (act_q == ACT_ALLOC) ? ST_SCAN : ST_FINAL;
					end else begin
						state_d = ST_SWEEP;
					end
				end
			end
			ST_FINAL: begin
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd_stall = (state_q != ST_IDLE);
		ram_wr_en = (state_q == ST_SCAN) && !ptr_end && !ptr_busy;
		ram_rd_en = swp_free;
		res       = '0;
		unique case (state_q)
			ST_EMIT: begin
				res.vld            = 1'b1;
				res.item.kind      = KIND_FREED;
				res.item.slot      = SLOT_W'(idx_q);
				res.item.freed_tag = ram_rd_data;
				res.item.last      = 1'b0;
			end
			ST_FINAL: begin
				res.vld            = 1'b1;
				res.item.kind      = fin_kind_q;
				res.item.slot      = SLOT_W'(fin_slot_q);
				res.item.freed_tag = '0;
				res.item.last      = 1'b1;
			end
			default: begin
				res = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			ptr_q      <= '0;
			idx_q      <= '0;
			act_q      <= ACT_ALLOC;
			tag_q      <= '0;
			swept_q    <= 1'b0;
			fin_kind_q <= KIND_DONE;
			fin_slot_q <= '0;
			in_use_q   <= '0;
			mark_q     <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_take) begin
						act_q      <= cmd.action;
						tag_q      <= cmd.type_tag;
						swept_q    <= 1'b0;
						idx_q      <= '0;
						fin_kind_q <= KIND_DONE;
						fin_slot_q <= '0;
					end
					if (mark_hit) begin
						mark_q[mk_ix] <= 1'b1;
					end
				end
				ST_SCAN: begin
					if (ptr_end) begin
						if (!swept_q) begin
							swept_q <= 1'b1;
							idx_q   <= '0;
						end else begin
							fin_kind_q <= KIND_EXHAUSTED;
							fin_slot_q <= '0;
						end
					end else if (ptr_busy) begin
						ptr_q <= ptr_q + 1'b1;
					end else begin
						in_use_q[ptr_ix] <= 1'b1;
						mark_q[ptr_ix]   <= 1'b0;
						fin_kind_q       <= KIND_ALLOC;
						fin_slot_q       <= ptr_ix;
						ptr_q            <= ptr_q + 1'b1;
					end
				end
				ST_SWEEP: begin
					if (swp_free) begin
						in_use_q[idx_q] <= 1'b0;
					end else begin
						mark_q[idx_q] <= 1'b0;
					end
				end
				default: begin
				end
			endcase
			// advance the sweep index, restart the pointer after the last slot
			if (adv) begin
				if (swp_last) begin
					ptr_q <= '0;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
			end
		end
	end

	shp_ram #(
		.WIDTH (TAG_W),
		.DEPTH (HEAP_SLOTS)
	) u_tag_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ptr_ix),
		.wr_data (tag_q),
		.rd_en   (ram_rd_en),
		.rd_addr (idx_q),
		.rd_data (ram_rd_data)
	);

endmodule

>>> hw/rtl/slot_heap_mark_sweep.sv
// ----------------------------------------------------------------------------
// slot_heap_mark_sweep: mark-and-sweep allocator over fixed-size slots
// Allocates, marks and sweeps slots; freed slots are reported with their tag.
// ----------------------------------------------------------------------------
//  channel | payload | handshake           | direction
//  cmd     | cmd_t   | cmd_valid/cmd_stall | into the block
//  rsp     | rsp_t   | rsp_valid/rsp_stall | out of the block
//
//  A mark is done in the idle state. A collect sweeps every slot, with a
//  notice for each freed slot, then ends with the closing transfer. An
//  allocate scans slot by slot, and when the scan runs off the end does a
//  full sweep and a second scan from slot zero. The sequencer visits one
//  slot per cycle but holds at each freed slot until its notice is taken.
//  Reset clears all slot bits and the pointer; no clearing pass is needed.
//  A stalled response holds the sequencer; the next command is taken while
//  the final response still waits in the output register.
// ----------------------------------------------------------------------------
module slot_heap_mark_sweep
	import shp_pkg::*;
#(
	parameter int HEAP_SLOTS = HEAP_SLOTS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_stall,
	input  cmd_t cmd,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	res_t res;
	logic res_ready;
	logic rsp_valid_q;
	rsp_t rsp_q;

	assign res_ready = !rsp_valid_q || !rsp_stall;

	shp_ctrl #(
		.HEAP_SLOTS (HEAP_SLOTS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.res_ready (res_ready),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_ready) begin
			rsp_valid_q <= res.vld;
		end
	end

	// payload: load on transfer into the output register
	always_ff @(posedge clk) begin
		if (res_ready && res.vld) begin
			rsp_q <= res.item;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

>>> hw/rtl/shp_checker.sv
// ----------------------------------------------------------------------------
// shp_checker: port-level checks of the slot heap allocator
// Watches the command and response channels; bound to the top level.
// ----------------------------------------------------------------------------
module shp_checker
	import shp_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	input logic cmd_stall,
	input cmd_t cmd,
	input logic rsp_valid,
	input logic rsp_stall,
	input rsp_t rsp
);

	// a stalled response stays offered
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid)
		else $error("response dropped while stalled");

	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> $stable(rsp))
		else $error("stalled response changed");

	// only freed notices leave last low
	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.last == (rsp.kind != KIND_FREED)))
		else $error("last flag does not match response kind");

	// allocate and collect occupy the sequencer after their transfer
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall && (cmd.action == ACT_ALLOC || cmd.action == ACT_COLLECT)
		|=> cmd_stall)
		else $error("block ready straight after allocate or collect");

endmodule

bind slot_heap_mark_sweep shp_checker u_shp_checker (.*);
